@@ hw/rtl/gfa_pkg.sv @@
// ----------------------------------------------------------------------------
// gfa_pkg - shared types and constants of the gravity force accumulator
// Widths, register indexes and the sequencer state type.
// ----------------------------------------------------------------------------
package gfa_pkg;

    localparam int FRAC_BITS = 16;
    localparam int REG_W     = 32;
    localparam int FORCE_W   = 48;
    localparam int POS_W     = 32;

    // configuration register indexes
    localparam logic [1:0] REG_GAIN    = 2'd0;
    localparam logic [1:0] REG_MIN_D   = 2'd1;
    localparam logic [1:0] REG_SOFT    = 2'd2;

    localparam logic [47:0] FMAX = {48{1'b1}};

    // sequencer states
    typedef enum logic [10:0] {
        ST_IDLE  = 11'b00000000001,
        ST_SQ    = 11'b00000000010,
        ST_ROOT1 = 11'b00000000100,
        ST_MUL1  = 11'b00000001000,
        ST_MUL2  = 11'b00000010000,
        ST_DIVF  = 11'b00000100000,
        ST_MULX  = 11'b00001000000,
        ST_DIVX  = 11'b00010000000,
        ST_MULY  = 11'b00100000000,
        ST_DIVY  = 11'b01000000000,
        ST_OUT   = 11'b10000000000
    } state_t;

endpackage

@@ hw/rtl/gravity_force_accumulator.sv @@
// ----------------------------------------------------------------------------
// gravity_force_accumulator - digit-serial 2D gravity force summation
// One attractor per input beat; one result beat per input beat.
// ----------------------------------------------------------------------------
// Each attractor passes from its input beat to its result beat through the
// stages below; the close branch is taken when it lies nearer than the
// minimum distance. The block works a bit at a time through one shared
// shift-and-add multiplier, one restoring square-root unit and one restoring
// divider. The squared distance takes two multiply passes; then come the
// distance root, the softened root in the close branch, the mass product in
// two passes (run empty in the close branch), the force divide, for each
// force component a multiply and a divide, and the result register. At zero
// distance the component stages are skipped. One attractor is worked at a
// time; the result beat sits in an output register and the next input beat
// is taken once the result has left. The registers are read part way through
// an attractor, so write them only while no beat is in flight.
module gravity_force_accumulator
    import gfa_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [31:0]  cfg_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    // own_x, own_y, own_mass, other_x, other_y, other_mass
    input  logic [191:0] s_tdata,
    // start_req
    input  logic         s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // total_x, total_y, peak_force, peak_x, peak_y
    output logic [207:0] m_tdata
);

    // configuration registers
    logic [31:0] gain_reg, mind_reg, soft_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg <= 32'h0001_0000;
            mind_reg <= 32'h0001_0000;
            soft_reg <= 32'h0001_0000;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_GAIN:  gain_reg <= cfg_data;
                REG_MIN_D: mind_reg <= cfg_data;
                REG_SOFT:  soft_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    state_t state_reg, state_next;
    logic [7:0]   cnt_reg;
    logic         last_step;
    logic         phase_reg;      // 0 first pass of a two-pass stage
    // operands held for the beat
    logic [32:0]  ax_reg, ay_reg;
    logic         sx_reg, sy_reg;
    logic [31:0]  tx_reg, ty_reg, om_reg, tm_reg;
    logic         start_reg;
    // shared datapath
    logic [127:0] acc_reg;        // product / numerator
    logic [63:0]  mcand_reg;      // multiplicand
    logic [63:0]  mplr_reg;       // multiplier, shifted right
    logic [127:0] rem_reg;        // divider / root remainder
    logic [127:0] num_reg;        // dividend shifted out
    logic [127:0] quo_reg;
    logic [127:0] d2_reg;
    logic [63:0]  dist_reg;
    logic [47:0]  f_reg;
    logic         far_reg;
    // results
    logic signed [47:0] accx_reg, accy_reg;
    logic [47:0]  best_reg;
    logic [31:0]  bx_reg, by_reg;
    logic         ovalid_reg;

    assign s_tready = (state_reg == ST_IDLE) && !ovalid_reg;
    assign m_tvalid = ovalid_reg;
    assign m_tdata  = {by_reg, bx_reg, best_reg, accy_reg, accx_reg};
    assign last_step = (cnt_reg == 8'd0);

    // offsets from the input beat
    logic signed [32:0] dx_w, dy_w;
    assign dx_w = $signed({s_tdata[127], s_tdata[127:96]})
                - $signed({s_tdata[31], s_tdata[31:0]});
    assign dy_w = $signed({s_tdata[159], s_tdata[159:128]})
                - $signed({s_tdata[63], s_tdata[63:32]});

    // root step: trial subtract of (4*root+1) at the current pair
    logic [129:0] sq_try;
    logic [129:0] sq_sub;
    assign sq_try = {rem_reg, num_reg[127:126]};
    assign sq_sub = {64'd0, quo_reg[63:0], 2'b01};

    // root bit of this step, full root and branch choice at the last step
    logic         root_bit;
    logic [63:0]  root_val;
    logic         far_now;
    assign root_bit = (sq_try >= sq_sub);
    assign root_val = {quo_reg[62:0], root_bit};
    assign far_now  = (root_val >= {32'd0, mind_reg});

    // shift-add multiply step
    logic [127:0] mul_sum;
    assign mul_sum = acc_reg + (mplr_reg[0] ? ({64'd0, mcand_reg} << (8'd63 - cnt_reg[5:0]))
                                            : 128'd0);

    // saturating accumulate helper
    function automatic logic signed [47:0] sat_add(input logic signed [47:0] a,
                                                   input logic [47:0] m, input logic neg);
        logic signed [49:0] s;
        begin
            s = neg ? ($signed({{2{a[47]}}, a}) - $signed({2'b00, m}))
                    : ($signed({{2{a[47]}}, a}) + $signed({2'b00, m}));
            if (s > 50'sh7FFF_FFFF_FFFF)       sat_add = 48'sh7FFF_FFFF_FFFF;
            else if (s < -50'sh8000_0000_0000) sat_add = 48'sh8000_0000_0000;
            else                               sat_add = s[47:0];
        end
    endfunction

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (s_tvalid && s_tready) state_next = ST_SQ;
            ST_SQ:    if (last_step && phase_reg) state_next = ST_ROOT1;
            ST_ROOT1: if (last_step) state_next = (phase_reg || far_now) ? ST_MUL1 : ST_ROOT1;
            ST_MUL1:  if (last_step) state_next = ST_MUL2;
            ST_MUL2:  if (last_step) state_next = ST_DIVF;
            ST_DIVF:  if (last_step) state_next = (dist_reg == 64'd0) ? ST_OUT : ST_MULX;
            ST_MULX:  if (last_step) state_next = ST_DIVX;
            ST_DIVX:  if (last_step) state_next = ST_MULY;
            ST_MULY:  if (last_step) state_next = ST_DIVY;
            ST_DIVY:  if (last_step) state_next = ST_OUT;
            ST_OUT:   state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            cnt_reg    <= 8'd0;
            phase_reg  <= 1'b0;
            ovalid_reg <= 1'b0;
            accx_reg   <= '0;
            accy_reg   <= '0;
            best_reg   <= '0;
            bx_reg     <= '0;
            by_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (ovalid_reg && m_tready)
                ovalid_reg <= 1'b0;
            unique case (state_reg) inside
                // latch the beat, start |dx|^2
                ST_IDLE:
                begin
                    if (s_tvalid && s_tready)
                    begin
                        start_reg <= s_tuser;
                        ax_reg    <= dx_w[32] ? 33'(-dx_w) : 33'(dx_w);
                        ay_reg    <= dy_w[32] ? 33'(-dy_w) : 33'(dy_w);
                        sx_reg    <= dx_w[32];
                        sy_reg    <= dy_w[32];
                        tx_reg    <= s_tdata[127:96];
                        ty_reg    <= s_tdata[159:128];
                        om_reg    <= s_tdata[95:64];
                        tm_reg    <= s_tdata[191:160];
                        mcand_reg <= dx_w[32] ? 64'(-dx_w) : 64'(unsigned'(dx_w));
                        mplr_reg  <= dx_w[32] ? 64'(-dx_w) : 64'(unsigned'(dx_w));
                        acc_reg   <= '0;
                        cnt_reg   <= 8'd63;
                        phase_reg <= 1'b0;
                    end
                end
                // d2 = ax^2 + ay^2, two multiply passes into one sum
                ST_SQ:
                begin
                    acc_reg  <= mul_sum;
                    mplr_reg <= mplr_reg >> 1;
                    cnt_reg  <= cnt_reg - 8'd1;
                    if (last_step)
                    begin
                        if (!phase_reg)
                        begin
                            phase_reg <= 1'b1;
                            mcand_reg <= {31'd0, ay_reg};
                            mplr_reg  <= {31'd0, ay_reg};
                            cnt_reg   <= 8'd63;
                        end
                        else
                        begin
                            d2_reg    <= mul_sum;
                            num_reg   <= mul_sum;
                            rem_reg   <= '0;
                            quo_reg   <= '0;
                            phase_reg <= 1'b0;
                            cnt_reg   <= 8'd63;
                        end
                    end
                end
                // bit-serial root: pass 0 gives dist, pass 1 the softened root
                ST_ROOT1:
                begin
                    num_reg <= num_reg << 2;
                    cnt_reg <= cnt_reg - 8'd1;
                    if (root_bit)
                    begin
                        rem_reg <= 128'(sq_try - sq_sub);
                        quo_reg <= {quo_reg[126:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= sq_try[127:0];
                        quo_reg <= {quo_reg[126:0], 1'b0};
                    end
                    if (last_step)
                    begin
                        cnt_reg <= 8'd63;
                        if (!phase_reg)
                        begin
                            dist_reg <= root_val;
                            far_reg  <= far_now;
                            if (far_now)
                            begin
                                // far: gain * own mass
                                mcand_reg <= {32'd0, gain_reg};
                                mplr_reg  <= {32'd0, om_reg};
                                acc_reg   <= '0;
                            end
                            else
                            begin
                                phase_reg <= 1'b1;
                                num_reg   <= d2_reg
                                           + {64'd0, {32'd0, soft_reg} * {32'd0, soft_reg}};
                                rem_reg   <= '0;
                                quo_reg   <= '0;
                            end
                        end
                        else
                        begin
                            // near: numerator 2^(2F), divisor the root
                            mcand_reg <= 64'd0;
                            mplr_reg  <= 64'd0;
                            acc_reg   <= 128'd1 << (2 * FRAC_BITS);
                            rem_reg   <= {64'd0, root_val};
                        end
                    end
                end
                // mass product, first pass (far) or idle pass (near)
                ST_MUL1:
                begin
                    if (far_reg)
                    begin
                        acc_reg  <= mul_sum;
                        mplr_reg <= mplr_reg >> 1;
                    end
                    cnt_reg <= cnt_reg - 8'd1;
                    if (last_step)
                    begin
                        cnt_reg <= 8'd63;
                        if (far_reg)
                        begin
                            mcand_reg <= mul_sum[63:0];
                            mplr_reg  <= {32'd0, tm_reg};
                            acc_reg   <= '0;
                        end
                    end
                end
                ST_MUL2:
                begin
                    if (far_reg)
                    begin
                        acc_reg  <= mul_sum;
                        mplr_reg <= mplr_reg >> 1;
                    end
                    cnt_reg <= cnt_reg - 8'd1;
                    if (last_step)
                    begin
                        cnt_reg <= 8'd127;
                        num_reg <= far_reg ? mul_sum : acc_reg;
                        // divisor kept in d2_reg
                        if (!far_reg) d2_reg <= rem_reg;
                        rem_reg <= '0;
                        quo_reg <= '0;
                    end
                end
                // restoring divide, 128 steps: the force, then the x and y components
                ST_DIVF, ST_DIVX, ST_DIVY:
                begin
                    logic [128:0] r2;
                    logic [128:0] t;
                    r2 = {rem_reg, num_reg[127]};
                    t  = r2 - {1'b0, d2_reg};
                    num_reg <= num_reg << 1;
                    cnt_reg <= cnt_reg - 8'd1;
                    if (!t[128])
                    begin
                        rem_reg <= t[127:0];
                        quo_reg <= {quo_reg[126:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= r2[127:0];
                        quo_reg <= {quo_reg[126:0], 1'b0};
                    end
                    if (last_step)
                    begin
                        logic [127:0] q;
                        logic [47:0]  qs;
                        q  = {quo_reg[126:0], !t[128]};
                        qs = (q[127:48] != 80'd0) ? FMAX : q[47:0];
                        if (d2_reg == 128'd0) qs = FMAX;
                        cnt_reg <= 8'd63;
                        acc_reg <= '0;
                        if (state_reg == ST_DIVF)
                        begin
                            f_reg     <= qs;
                            mcand_reg <= {16'd0, qs};
                            mplr_reg  <= {31'd0, ax_reg};
                            d2_reg    <= {64'd0, dist_reg};
                            if (start_reg)
                            begin
                                accx_reg <= '0;
                                accy_reg <= '0;
                                best_reg <= '0;
                            end
                        end
                        else if (state_reg == ST_DIVX)
                        begin
                            accx_reg <= sat_add(accx_reg, qs, sx_reg);
                            mplr_reg <= {31'd0, ay_reg};
                            mcand_reg <= {16'd0, f_reg};
                        end
                        else
                        begin
                            accy_reg <= sat_add(accy_reg, qs, sy_reg);
                        end
                    end
                end
                // component numerator F * |d|
                ST_MULX, ST_MULY:
                begin
                    acc_reg  <= mul_sum;
                    mplr_reg <= mplr_reg >> 1;
                    cnt_reg  <= cnt_reg - 8'd1;
                    if (last_step)
                    begin
                        num_reg <= mul_sum;
                        rem_reg <= '0;
                        quo_reg <= '0;
                        cnt_reg <= 8'd127;
                    end
                end
                // zero-distance x update, peak update, present the result
                ST_OUT:
                begin
                    if (dist_reg == 64'd0)
                        accx_reg <= sat_add(accx_reg, f_reg, 1'b0);
                    if (f_reg > best_reg)
                    begin
                        best_reg <= f_reg;
                        bx_reg   <= tx_reg;
                        by_reg   <= ty_reg;
                    end
                    ovalid_reg <= 1'b1;
                end
                default: ;
            endcase
        end
    end

endmodule

@@ hw/rtl/gfa_checker.sv @@
// ----------------------------------------------------------------------------
// gfa_checker - port-level checks of the gravity force accumulator
// Watches the stream ports only.
// ----------------------------------------------------------------------------
module gfa_port_checks
    import gfa_pkg::*;
(
    input logic         clk,
    input logic         rst_n,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [207:0] m_tdata
);

    // no new beat taken while a result waits
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !s_tready) else $error("input taken with result pending");

    // a result never follows an input beat in the next cycle
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !m_tvalid) else $error("result too early");

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result dropped or changed");

endmodule

bind gravity_force_accumulator gfa_port_checks u_gfa_port_checks (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

@@ tb/gfa_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfa_checker - result predictor and scoreboard for the force accumulator
// Watches the configuration port and both stream channels, works out the
// expected result of every accepted input beat and compares each result beat
// field by field with the oldest outstanding expectation.
// ----------------------------------------------------------------------------
module gfa_checker
    import gfa_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [31:0]  cfg_data,
    input  logic         s_tvalid,
    input  logic         s_tready,
    // own_x, own_y, own_mass, other_x, other_y, other_mass
    input  logic [191:0] s_tdata,
    // start_req
    input  logic         s_tuser,
    input  logic         m_tvalid,
    input  logic         m_tready,
    // total_x, total_y, peak_force, peak_x, peak_y
    input  logic [207:0] m_tdata,
    output int           fail_count,
    output int           pending,
    output int           results_seen
);

    // highest field first, so total_x lands in the lowest bits
    typedef struct packed {
        logic signed [31:0] peak_y;
        logic signed [31:0] peak_x;
        logic [47:0]        peak_force;
        logic signed [47:0] total_y;
        logic signed [47:0] total_x;
    } force_sum_t;

    localparam longint SUM_MAX = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint SUM_MIN = -64'sh0000_8000_0000_0000;

    // predictor copy of the registers and of the running sums
    logic [31:0] gain_q, min_dist_q, soft_q;
    longint      sum_x, sum_y;
    logic [47:0] strongest;
    logic [31:0] strongest_x, strongest_y;

    force_sum_t expected_sums[$];

    // floored square root of a 128-bit value
    function automatic logic [63:0] floor_sqrt(input logic [127:0] v);
        logic [63:0]  root;
        logic [127:0] cand;
        root = '0;
        for (int i = 63; i >= 0; i--) begin
            cand = {64'd0, root | (64'd1 << i)};
            if (cand * cand <= v)
                root = cand[63:0];
        end
        return root;
    endfunction

    // truncating quotient clamped to the force range
    function automatic logic [47:0] div_clamp(input logic [127:0] n, input logic [127:0] d);
        logic [127:0] q;
        q = n / d;
        return (q > {80'd0, FMAX}) ? FMAX : q[47:0];
    endfunction

    function automatic longint clamp_sum(input longint v);
        return (v > SUM_MAX) ? SUM_MAX : ((v < SUM_MIN) ? SUM_MIN : v);
    endfunction

    // one attractor: update the sums and return the result beat
    function automatic force_sum_t add_attractor(input logic start, input logic [191:0] d);
        logic signed [31:0] ox, oy, tx, ty;
        logic [31:0]  om, tm;
        longint       dx, dy, fx, fy, mx, my;
        logic [127:0] ax, ay, d2, dist_v, root;
        logic [47:0]  f;
        force_sum_t   r;
        ox = d[31:0];    oy = d[63:32];   om = d[95:64];
        tx = d[127:96];  ty = d[159:128]; tm = d[191:160];
        dx = longint'(tx) - longint'(ox);
        dy = longint'(ty) - longint'(oy);
        ax = (dx < 0) ? 128'(-dx) : 128'(dx);
        ay = (dy < 0) ? 128'(-dy) : 128'(dy);
        d2 = ax * ax + ay * ay;
        dist_v = {64'd0, floor_sqrt(d2)};

        if (start)
        begin
            sum_x = 0;
            sum_y = 0;
            strongest = '0;
        end

        // far branch scales by mass, close branch is softened
        if (dist_v >= {96'd0, min_dist_q})
        begin
            if (d2 == 0)
                f = FMAX;
            else
                f = div_clamp((128'(gain_q) * 128'(om)) * 128'(tm), d2);
        end
        else
        begin
            root = {64'd0, floor_sqrt(d2 + 128'(soft_q) * 128'(soft_q))};
            if (root == 0)
                f = FMAX;
            else
                f = div_clamp(128'd1 << (2 * FRAC_BITS), root);
        end

        // zero distance puts everything on x
        if (dist_v == 0)
        begin
            fx = longint'({16'd0, f});
            fy = 0;
        end
        else
        begin
            mx = longint'({16'd0, div_clamp(128'(f) * ax, dist_v)});
            my = longint'({16'd0, div_clamp(128'(f) * ay, dist_v)});
            fx = (dx < 0) ? -mx : mx;
            fy = (dy < 0) ? -my : my;
        end
        sum_x = clamp_sum(sum_x + fx);
        sum_y = clamp_sum(sum_y + fy);

        if (f > strongest)
        begin
            strongest = f;
            strongest_x = tx;
            strongest_y = ty;
        end

        r.total_x = sum_x[47:0];
        r.total_y = sum_y[47:0];
        r.peak_force = strongest;
        r.peak_x = strongest_x;
        r.peak_y = strongest_y;
        return r;
    endfunction

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("[%0t] mismatch on %s: got %h, expected %h", $time, what, got, want);
        fail_count++;
    endtask

    // register writes, input beats and result beats
    always @(posedge clk or negedge rst_n)
    begin
        force_sum_t got, want;
        if (!rst_n)
        begin
            gain_q <= 32'd65536;
            min_dist_q <= 32'd65536;
            soft_q <= 32'd65536;
            sum_x = 0;
            sum_y = 0;
            strongest = '0;
            strongest_x = '0;
            strongest_y = '0;
            expected_sums.delete();
            fail_count = 0;
            results_seen <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_GAIN:  gain_q <= cfg_data;
                    REG_MIN_D: min_dist_q <= cfg_data;
                    REG_SOFT:  soft_q <= cfg_data;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                expected_sums.push_back(add_attractor(s_tuser, s_tdata));
            if (m_tvalid && m_tready)
            begin
                got = m_tdata;
                results_seen <= results_seen + 1;
                if (expected_sums.size() == 0)
                begin
                    $display("[%0t] result beat with nothing outstanding", $time);
                    fail_count++;
                end
                else
                begin
                    want = expected_sums.pop_front();
                    if (got.total_x !== want.total_x)
                        report("total_x", 64'(got.total_x), 64'(want.total_x));
                    if (got.total_y !== want.total_y)
                        report("total_y", 64'(got.total_y), 64'(want.total_y));
                    if (got.peak_force !== want.peak_force)
                        report("peak_force", 64'(got.peak_force), 64'(want.peak_force));
                    if (got.peak_x !== want.peak_x)
                        report("peak_x", 64'(got.peak_x), 64'(want.peak_x));
                    if (got.peak_y !== want.peak_y)
                        report("peak_y", 64'(got.peak_y), 64'(want.peak_y));
                end
            end
        end
    end

    assign pending = expected_sums.size();

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top - stimulus and verdict for the gravity force accumulator
// Directed attractors on the corner cases, then random attractors over
// several register settings, with random gaps on input and output.
// ----------------------------------------------------------------------------
module tb_top
    import gfa_pkg::*;
;

    localparam int RANDOM_ATTRACTORS = 1720;
    localparam int SETTINGS_COUNT    = 6;
    localparam int STALL_LIMIT       = 6000;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         cfg_we = 1'b0;
    logic [1:0]   cfg_index = REG_GAIN;
    logic [31:0]  cfg_data = '0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [191:0] s_tdata = '0;
    logic         s_tuser = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [207:0] m_tdata;

    int  fail_count, pending, results_seen;
    int  attractors_sent = 0;
    int  idle_cycles = 0;
    bit  drain_done = 1'b0;
    bit  steady_sink = 1'b0;

    always #5 clk = ~clk;

    gravity_force_accumulator dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    gfa_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .fail_count(fail_count), .pending(pending), .results_seen(results_seen)
    );

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 60) return 0;
        if (pick < 95) return $urandom_range(1, 4);
        return $urandom_range(20, 90);
    endfunction

    // result side back-pressure, with stretches of none
    always @(posedge clk)
    begin
        if (steady_sink || $urandom_range(0, 3) != 0)
            m_tready <= 1'b1;
        else
            m_tready <= 1'b0;
        if ($urandom_range(0, 499) == 0)
            steady_sink <= !steady_sink;
    end

    // stall watchdog
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we || drain_done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("timeout after %0d cycles without a beat", idle_cycles);
            $display("FAIL gravity_force_accumulator");
            $finish;
        end
    end

    task automatic send_attractor(input logic start, input logic signed [31:0] ox,
                                  input logic signed [31:0] oy, input logic [31:0] om,
                                  input logic signed [31:0] tx, input logic signed [31:0] ty,
                                  input logic [31:0] tm);
        int gap;
        gap = gap_len();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= start;
        s_tdata <= {tm, ty, tx, om, oy, ox};
        do @(posedge clk); while (!s_tready);
        attractors_sent++;
    endtask

    // registers change only with nothing in flight
    task automatic set_registers(input logic [31:0] g, input logic [31:0] md,
                                 input logic [31:0] sl);
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        cfg_we <= 1'b1; cfg_index <= REG_GAIN;  cfg_data <= g;
        @(posedge clk);
        cfg_index <= REG_MIN_D; cfg_data <= md;
        @(posedge clk);
        cfg_index <= REG_SOFT;  cfg_data <= sl;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [31:0] rand_mass();
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 32'h0004_0000);
            1: return 32'hFFFF_FFFF - $urandom_range(0, 15);
            default: return $urandom();
        endcase
    endfunction

    task automatic random_attractor();
        logic signed [31:0] ox, oy, tx, ty;
        int spread;
        ox = $urandom();
        oy = $urandom();
        // mostly near the body so both force branches and signs show up
        case ($urandom_range(0, 5))
            0: begin tx = $urandom(); ty = $urandom(); end
            1: begin tx = ox; ty = oy; end
            default:
            begin
                spread = 1 << $urandom_range(0, 24);
                tx = ox + $urandom_range(0, 2 * spread) - spread;
                ty = oy + $urandom_range(0, 2 * spread) - spread;
            end
        endcase
        send_attractor($urandom_range(0, 9) == 0, ox, oy, rand_mass(), tx, ty, rand_mass());
    endtask

    initial
    begin
        logic [31:0] g, md, sl;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed corner cases at reset settings
        send_attractor(1'b1, 32'sd0, 32'sd0, 32'h0001_0000, 32'sd0, 32'sd0, 32'h0001_0000);
        send_attractor(1'b0, 32'sh0001_0000, 32'sd0, 32'h0001_0000,
                       32'sh0003_0000, 32'sh0004_0000, 32'h0002_0000);
        send_attractor(1'b0, 32'sh8000_0000, 32'sh8000_0000, 32'hFFFF_FFFF,
                       32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'hFFFF_FFFF);
        send_attractor(1'b0, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'h0,
                       32'sh8000_0000, 32'sh7FFF_FFFF, 32'h0);
        send_attractor(1'b0, 32'sd0, 32'sd0, 32'h1, 32'sh0000_8000, -32'sh0000_8000, 32'h1);
        send_attractor(1'b1, 32'sd5, 32'sd5, 32'h0001_0000, -32'sh0005_0000, 32'sd5, 32'h0);

        // far branch everywhere, heaviest gain: saturation and zero-distance clamp
        set_registers(32'hFFFF_FFFF, 32'h0, 32'h1);
        send_attractor(1'b1, 32'sd0, 32'sd0, 32'hFFFF_FFFF, 32'sd0, 32'sd0, 32'hFFFF_FFFF);
        for (int i = 0; i < 4; i++)
            send_attractor(1'b0, 32'sd0, 32'sd0, 32'hFFFF_FFFF,
                           32'sd1, -32'sd1, 32'hFFFF_FFFF);
        for (int i = 0; i < 4; i++)
            send_attractor(1'b0, 32'sd0, 32'sd0, 32'hFFFF_FFFF,
                           -32'sd3, 32'sd2, 32'hFFFF_FFFF);

        // largest minimum distance, so mostly the close branch; widest softening, then the least
        set_registers(32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_attractor(1'b1, 32'sd0, 32'sd0, 32'h0, 32'sd0, 32'sd0, 32'h0);
        send_attractor(1'b0, 32'sh8000_0000, 32'sd0, 32'h5,
                       32'sh7FFF_FFFF, 32'sd0, 32'h5);
        set_registers(32'h0, 32'hFFFF_FFFF, 32'h1);
        send_attractor(1'b0, 32'sd0, 32'sd0, 32'h0, 32'sd0, 32'sd0, 32'h0);
        send_attractor(1'b0, 32'sd0, 32'sd0, 32'h0, 32'sd0, 32'sd1, 32'h0);

        // random attractors across several register settings
        for (int phase = 0; phase < SETTINGS_COUNT; phase++)
        begin
            case (phase)
                0: begin g = 32'h0001_0000; md = 32'h0001_0000; sl = 32'h0001_0000; end
                1: begin g = 32'hFFFF_FFFF; md = 32'h0;         sl = 32'h1;         end
                2: begin g = 32'h0;         md = 32'hFFFF_FFFF; sl = 32'hFFFF_FFFF; end
                default:
                begin
                    g = $urandom();
                    md = $urandom_range(0, 32'h0100_0000);
                    sl = $urandom_range(1, 32'h0010_0000);
                end
            endcase
            set_registers(g, md, sl);
            for (int i = 0; i < RANDOM_ATTRACTORS / SETTINGS_COUNT; i++)
                random_attractor();
        end

        // drain and verdict
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        drain_done <= 1'b1;
        repeat (50) @(posedge clk);
        $display("run covered %0d attractors over %0d register settings, %0d results checked",
                 attractors_sent, SETTINGS_COUNT + 4, results_seen);
        if (fail_count == 0 && results_seen == attractors_sent)
            $display("PASS gravity_force_accumulator");
        else
            $display("FAIL gravity_force_accumulator");
        $finish;
    end

endmodule
